// ===== hdl/hptc_pkg.sv =====
// ----------------------------------------------------------------------------
// hptc_pkg
// shared types and constants for the heading turn controller
// ----------------------------------------------------------------------------
package hptc_pkg;

  localparam int HEADING_W = 9;
  localparam int GAIN_W    = 12;
  localparam int ERR_W     = 8;
  localparam int INTEG_W   = 16;
  localparam int DERIV_W   = 9;
  localparam int SUM_W     = 31;
  localparam int DRIVE_W   = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [HEADING_W-1:0] FULL_TURN = 9'd360;
  localparam logic [HEADING_W-1:0] HALF_TURN = 9'd180;
  localparam logic [DRIVE_W-1:0]   DRIVE_LIMIT = 8'd100;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 3'd5;

  typedef struct packed {
    logic [HEADING_W-1:0] target_heading;
    logic [GAIN_W-1:0]    gain_p;
    logic [GAIN_W-1:0]    gain_i;
    logic [GAIN_W-1:0]    gain_d;
    logic [ERR_W-1:0]     windup_band;
    logic [ERR_W-1:0]     settle_threshold;
  } cfg_t;

  // one classified step, handed from the front to the back
  typedef struct packed {
    logic [ERR_W-1:0]          err;
    logic [INTEG_W-1:0]        integ;
    logic signed [DERIV_W-1:0] deriv;
    logic                      turn_right;
    logic                      settled;
  } step_t;

endpackage

// ===== hdl/heading_pid_turn_controller.sv =====
// ----------------------------------------------------------------------------
// heading_pid_turn_controller
// pid turn controller steering toward a configured compass heading
// ----------------------------------------------------------------------------
// Each input word carries one heading sample; each gives exactly one result
// word with the drive percent, turn direction, wrapped error and settled flag.
// One word is taken every clock while the output side keeps up: the front
// computes the error and updates the integral sum and previous error in the
// cycle of acceptance, and that state update sets the rate. The back runs
// the three gain products, the pid sum and the truncating saturation as a
// three-stage pipeline of product, sum and output registers. A four-entry
// queue between front and back lets input keep flowing for a few words
// while the output side is stalled.
// Configuration writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module heading_pid_turn_controller #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  // heading input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [8:0] heading, [9] start_req, rest zero
  // drive output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [7:0] drive_speed, [8] turn_right,
                                      // [16:9] heading_error, [17] settled
);

  hptc_pkg::cfg_t  cfg;
  hptc_pkg::step_t front_word;
  hptc_pkg::step_t queue_word;
  logic            queue_full;
  logic            queue_valid;
  logic            back_ready;
  logic            in_accept;

  logic [hptc_pkg::DRIVE_W-1:0] drive_speed;
  logic                         turn_right;
  logic [hptc_pkg::ERR_W-1:0]   heading_error;
  logic                         settled;

  assign s_axis_tready = !queue_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // configuration registers, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_heading   <= 9'd0;
      cfg.gain_p           <= 12'd77;
      cfg.gain_i           <= 12'd15;
      cfg.gain_d           <= 12'd26;
      cfg.windup_band      <= 8'd5;
      cfg.settle_threshold <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hptc_pkg::REG_TARGET: cfg.target_heading   <= cfg_data[hptc_pkg::HEADING_W-1:0];
        hptc_pkg::REG_GAIN_P: cfg.gain_p           <= cfg_data;
        hptc_pkg::REG_GAIN_I: cfg.gain_i           <= cfg_data;
        hptc_pkg::REG_GAIN_D: cfg.gain_d           <= cfg_data;
        hptc_pkg::REG_WINDUP: cfg.windup_band      <= cfg_data[hptc_pkg::ERR_W-1:0];
        hptc_pkg::REG_SETTLE: cfg.settle_threshold <= cfg_data[hptc_pkg::ERR_W-1:0];
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  // front: error, direction and controller state
  hptc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (in_accept),
    .heading   (s_axis_tdata[8:0]),
    .start_req (s_axis_tdata[9]),
    .step      (front_word)
  );

  // decoupling queue
  hptc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_accept),
    .wr_word  (front_word),
    .full     (queue_full),
    .pop      (queue_valid && back_ready),
    .rd_valid (queue_valid),
    .rd_word  (queue_word)
  );

  // back: products, sum and saturation
  hptc_back #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (queue_valid),
    .in_ready      (back_ready),
    .in_word       (queue_word),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .drive_speed   (drive_speed),
    .turn_right    (turn_right),
    .heading_error (heading_error),
    .settled       (settled)
  );

  assign m_axis_tdata = {6'd0, settled, heading_error, turn_right, drive_speed};

endmodule

// ===== hdl/hptc_front.sv =====
// ----------------------------------------------------------------------------
// hptc_front
// wrapped heading error, direction and integral / previous error update
// ----------------------------------------------------------------------------
module hptc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  hptc_pkg::cfg_t                  cfg,
  input  logic                            push,
  input  logic [hptc_pkg::HEADING_W-1:0]  heading,
  input  logic                            start_req,
  output hptc_pkg::step_t                 step
);

  logic [hptc_pkg::INTEG_W-1:0]   integral_sum;
  logic [hptc_pkg::INTEG_W-1:0]   integral_sum_next;
  logic [hptc_pkg::ERR_W-1:0]     last_error;

  logic signed [hptc_pkg::HEADING_W:0] diff;
  logic [hptc_pkg::HEADING_W-1:0] mag;
  logic [hptc_pkg::HEADING_W-1:0] d;
  logic [hptc_pkg::HEADING_W-1:0] err_wide;
  logic [hptc_pkg::ERR_W-1:0]     err;
  logic                           right;
  logic [hptc_pkg::INTEG_W-1:0]   integ_base;
  logic [hptc_pkg::ERR_W-1:0]     last_base;
  logic [hptc_pkg::INTEG_W:0]     integ_add;
  logic [hptc_pkg::DERIV_W-1:0]   deriv;

  always_comb begin
    diff = $signed({1'b0, cfg.target_heading}) - $signed({1'b0, heading});
    mag  = diff[hptc_pkg::HEADING_W] ? hptc_pkg::HEADING_W'(-diff) : diff[hptc_pkg::HEADING_W-1:0];
    d    = (mag >= hptc_pkg::FULL_TURN) ? mag - hptc_pkg::FULL_TURN : mag;
    err_wide = (d > hptc_pkg::HALF_TURN) ? hptc_pkg::FULL_TURN - d : d;
    err  = err_wide[hptc_pkg::ERR_W-1:0];
    // a negative difference wraps to a full turn minus its magnitude
    if (!diff[hptc_pkg::HEADING_W]) begin
      right = (d <= hptc_pkg::HALF_TURN);
    end else begin
      right = (d == '0) || (d >= hptc_pkg::HALF_TURN);
    end

    integ_base = start_req ? '0 : integral_sum;
    last_base  = start_req ? '0 : last_error;
    integ_add  = {1'b0, integ_base} + {{(hptc_pkg::INTEG_W + 1 - hptc_pkg::ERR_W){1'b0}}, err};
    integral_sum_next = integ_add[hptc_pkg::INTEG_W] ? '1 : integ_add[hptc_pkg::INTEG_W-1:0];
    if ((err < cfg.settle_threshold) || (err > cfg.windup_band)) begin
      integral_sum_next = '0;
    end
    deriv = {1'b0, err} - {1'b0, last_base};

    step.err        = err;
    step.integ      = integral_sum_next;
    step.deriv      = $signed(deriv);
    step.turn_right = right;
    step.settled    = (err <= cfg.settle_threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      last_error   <= '0;
    end else if (push) begin
      integral_sum <= integral_sum_next;
      last_error   <= err;
    end
  end

endmodule

// ===== hdl/hptc_queue.sv =====
// ----------------------------------------------------------------------------
// hptc_queue
// short register queue between the front and the back
// ----------------------------------------------------------------------------
module hptc_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hptc_pkg::step_t wr_word,
  output logic            full,
  input  logic            pop,
  output logic            rd_valid,
  output hptc_pkg::step_t rd_word
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  hptc_pkg::step_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_word  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/hptc_back.sv =====
// ----------------------------------------------------------------------------
// hptc_back
// gain products, pid sum, truncation and drive saturation
// ----------------------------------------------------------------------------
module hptc_back #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hptc_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hptc_pkg::step_t               in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hptc_pkg::DRIVE_W-1:0]  drive_speed,
  output logic                          turn_right,
  output logic [hptc_pkg::ERR_W-1:0]    heading_error,
  output logic                          settled
);

  localparam int PP_W = hptc_pkg::GAIN_W + hptc_pkg::ERR_W;
  localparam int PI_W = hptc_pkg::GAIN_W + hptc_pkg::INTEG_W;
  localparam int PD_W = hptc_pkg::GAIN_W + 1 + hptc_pkg::DERIV_W;

  // product stage
  logic                          a_valid;
  logic                          a_ready;
  logic [PP_W-1:0]               a_prod_p;
  logic [PI_W-1:0]               a_prod_i;
  logic signed [PD_W-1:0]        a_prod_d;
  logic [hptc_pkg::ERR_W-1:0]    a_err;
  logic                          a_right;
  logic                          a_settled;

  // sum stage
  logic                          b_valid;
  logic                          b_ready;
  logic signed [hptc_pkg::SUM_W-1:0] b_sum;
  logic [hptc_pkg::ERR_W-1:0]    b_err;
  logic                          b_right;
  logic                          b_settled;

  logic signed [hptc_pkg::SUM_W-1:0] sum_next;
  logic [hptc_pkg::SUM_W-1:0]    mag;
  logic [hptc_pkg::SUM_W-1:0]    quot;
  logic [hptc_pkg::DRIVE_W-1:0]  limited;
  logic [hptc_pkg::DRIVE_W-1:0]  speed_next;

  assign in_ready = !a_valid || a_ready;
  assign a_ready  = !b_valid || b_ready;
  assign b_ready  = !out_valid || out_ready;

  always_comb begin
    sum_next = $signed({{(hptc_pkg::SUM_W - PP_W){1'b0}}, a_prod_p})
             + $signed({{(hptc_pkg::SUM_W - PI_W){1'b0}}, a_prod_i})
             + hptc_pkg::SUM_W'(a_prod_d);
    mag     = b_sum[hptc_pkg::SUM_W-1] ? hptc_pkg::SUM_W'(-b_sum) : hptc_pkg::SUM_W'(b_sum);
    quot    = mag >> GAIN_FRAC_BITS;
    limited = (quot > hptc_pkg::SUM_W'(hptc_pkg::DRIVE_LIMIT)) ? hptc_pkg::DRIVE_LIMIT
                                                               : quot[hptc_pkg::DRIVE_W-1:0];
    speed_next = b_sum[hptc_pkg::SUM_W-1] ? -limited : limited;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (a_ready) begin
        b_valid <= a_valid;
      end
      if (b_ready) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_prod_p  <= PP_W'(cfg.gain_p) * PP_W'(in_word.err);
      a_prod_i  <= PI_W'(cfg.gain_i) * PI_W'(in_word.integ);
      a_prod_d  <= $signed({1'b0, cfg.gain_d}) * in_word.deriv;
      a_err     <= in_word.err;
      a_right   <= in_word.turn_right;
      a_settled <= in_word.settled;
    end
    if (a_ready && a_valid) begin
      b_sum     <= sum_next;
      b_err     <= a_err;
      b_right   <= a_right;
      b_settled <= a_settled;
    end
    if (b_ready && b_valid) begin
      drive_speed   <= speed_next;
      heading_error <= b_err;
      turn_right    <= b_right;
      settled       <= b_settled;
    end
  end

endmodule

// ===== bench/heading_pid_turn_controller_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pid_turn_controller_test
// self-checking bench for the heading pid turn controller
// ----------------------------------------------------------------------------
// A directed table covers the wrap-around of the heading error, the half-turn
// direction, out-of-range headings and targets, drive saturation both ways and
// the register masks. Mixed phases with random settings follow, then a long
// soak that drives the integral sum into saturation. Every result word is
// checked field by field against a hand-typed value or a copy of the controller.
// ----------------------------------------------------------------------------
module heading_pid_turn_controller_test;
  import hptc_pkg::*;

  localparam int FRAC_BITS       = 8;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int TAIL_CYCLES     = 12;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int MIX_PHASES      = 4;
  localparam int MIX_WORDS       = 18;
  localparam int SOAK_WORDS      = 390;
  localparam int INTEG_MAX       = 65535;
  localparam int DRIVE_MAX       = 100;
  localparam int MAX_REPORTS     = 10;

  // index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // one result word, laid out as on m_axis_tdata
  typedef struct packed {
    logic                      settled;
    logic [ERR_W-1:0]          err;
    logic                      turn_right;
    logic signed [DRIVE_W-1:0] drive;
  } drive_word_t;

  // one row of the directed table: a register write or a heading word
  typedef struct packed {
    logic                 is_reg;
    logic                 typed;
    logic [CFG_IDX_W-1:0] idx;
    logic [GAIN_W-1:0]    val;
    logic [HEADING_W-1:0] heading;
    logic                 start_req;
    drive_word_t          want;
  } stim_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [15:0] in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] out_data;

  // predictor state and its copy of the registers
  cfg_t steer_cfg;
  int   integ_acc;
  int   prev_err;

  drive_word_t pending_drive[$];
  stim_row_t   stim_rows[$];

  int bad_words        = 0;
  int cycles           = 0;
  bit smooth           = 1'b0;
  bit hold_off_pending = 1'b0;

  heading_pid_turn_controller #(
    .GAIN_FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_data),     // [8:0] heading, [9] start_req, rest zero
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data)     // [7:0] drive_speed, [8] turn_right,
                                  // [16:9] heading_error, [17] settled
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 60) return 0;
    if (roll < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return 12'($urandom_range(0, 255));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // band and threshold values; wide writes exercise the upper data bits
  function automatic logic [GAIN_W-1:0] pick_band();
    case ($urandom_range(0, 5))
      0: return 12'($urandom_range(0, 4095));
      1: return 12'd180;
      2: return '0;
      default: return 12'($urandom_range(0, 20));
    endcase
  endfunction

  // one controller step: wrapped error, direction, integral, pid and clamp
  function automatic drive_word_t steer_step(input logic [HEADING_W-1:0] hd,
                                             input logic st);
    int          tgt, diff, abs_diff, err, wrap, deriv, speed;
    longint      pid, mag;
    drive_word_t res;
    if (st) begin
      integ_acc = 0;
      prev_err  = 0;
    end
    tgt  = int'(steer_cfg.target_heading);
    diff = tgt - int'(hd);
    abs_diff = (diff < 0) ? -diff : diff;
    abs_diff = abs_diff % 360;
    err  = (abs_diff > 180) ? 360 - abs_diff : abs_diff;
    // signed remainder brought into 0..359, half turn goes right
    wrap = diff % 360;
    if (wrap < 0) wrap = wrap + 360;

    integ_acc = integ_acc + err;
    if (integ_acc > INTEG_MAX) integ_acc = INTEG_MAX;
    deriv    = err - prev_err;
    prev_err = err;
    // clearing comes after accumulation and before the pid sum
    if (err < int'(steer_cfg.settle_threshold)) integ_acc = 0;
    if (err > int'(steer_cfg.windup_band)) integ_acc = 0;

    pid = longint'(steer_cfg.gain_p) * longint'(err)
        + longint'(steer_cfg.gain_i) * longint'(integ_acc)
        + longint'(steer_cfg.gain_d) * longint'(deriv);
    // truncate toward zero, then clamp to the percent range
    if (pid < 0) begin
      mag   = (-pid) >> FRAC_BITS;
      speed = (mag > DRIVE_MAX) ? -DRIVE_MAX : -int'(mag);
    end else begin
      mag   = pid >> FRAC_BITS;
      speed = (mag > DRIVE_MAX) ? DRIVE_MAX : int'(mag);
    end

    res.drive      = 8'(speed);
    res.turn_right = (wrap <= 180);
    res.err        = 8'(err);
    res.settled    = (err <= int'(steer_cfg.settle_threshold));
    return res;
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [GAIN_W-1:0] val);
    stim_row_t row;
    row        = '0;
    row.is_reg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_step(input logic [HEADING_W-1:0] hd, input logic st);
    stim_row_t row;
    row           = '0;
    row.heading   = hd;
    row.start_req = st;
    stim_rows.push_back(row);
  endfunction

  // heading word whose result is written out by hand
  function automatic void add_checked(input logic [HEADING_W-1:0] hd, input logic st,
                                      input logic signed [DRIVE_W-1:0] drive,
                                      input logic right, input logic [ERR_W-1:0] err,
                                      input logic settled);
    stim_row_t row;
    row                 = '0;
    row.typed           = 1'b1;
    row.heading         = hd;
    row.start_req       = st;
    row.want.drive      = drive;
    row.want.turn_right = right;
    row.want.err        = err;
    row.want.settled    = settled;
    stim_rows.push_back(row);
  endfunction

  // register write, mirrored into the predictor; block is idle here
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_TARGET: steer_cfg.target_heading   = val[HEADING_W-1:0];
      REG_GAIN_P: steer_cfg.gain_p           = val;
      REG_GAIN_I: steer_cfg.gain_i           = val;
      REG_GAIN_D: steer_cfg.gain_d           = val;
      REG_WINDUP: steer_cfg.windup_band      = val[ERR_W-1:0];
      REG_SETTLE: steer_cfg.settle_threshold = val[ERR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // offer one heading word, record its expected result once it is taken
  task automatic push_heading(input logic [HEADING_W-1:0] hd, input logic st,
                              input logic typed, input drive_word_t want);
    drive_word_t predicted;
    int          gap;
    in_valid <= 1'b1;
    in_data  <= {6'b0, st, hd};
    do @(posedge clk); while (!in_ready);
    predicted = steer_step(hd, st);
    pending_drive.push_back(typed ? want : predicted);
    @(negedge clk);
    gap = smooth ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // stop offering and let every outstanding result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    stim_row_t row;
    int        tgt, span, hd;
    steer_cfg.target_heading   = 9'd0;
    steer_cfg.gain_p           = 12'd77;
    steer_cfg.gain_i           = 12'd15;
    steer_cfg.gain_d           = 12'd26;
    steer_cfg.windup_band      = 8'd5;
    steer_cfg.settle_threshold = 8'd1;
    integ_acc = 0;
    prev_err  = 0;

    // reset settings: on target, half turn, either side of it, wrap at north
    add_checked(9'd0, 1'b0, 8'sd0, 1'b1, 8'd0, 1'b1);
    add_step(9'd180, 1'b1);
    add_step(9'd181, 1'b0);
    add_step(9'd179, 1'b0);
    add_step(9'd359, 1'b0);
    add_step(9'd1, 1'b0);
    add_step(9'd511, 1'b0);
    add_step(9'd360, 1'b1);
    // small errors inside the band build up the integral, zero error clears it
    add_step(9'd3, 1'b0);
    add_step(9'd3, 1'b0);
    add_step(9'd2, 1'b0);
    add_step(9'd0, 1'b0);
    add_reg(REG_TARGET, 12'd359);
    add_step(9'd0, 1'b0);
    add_step(9'd358, 1'b0);
    // largest target the register holds
    add_reg(REG_TARGET, 12'd511);
    add_step(9'd0, 1'b0);
    add_step(9'd511, 1'b0);
    add_reg(REG_SPARE, 12'hFFF);
    add_step(9'd100, 1'b1);
    // full P and D gains: positive clamp, then a falling error gives the negative clamp
    add_reg(REG_TARGET, 12'd0);
    add_reg(REG_GAIN_P, 12'hFFF);
    add_reg(REG_GAIN_I, 12'd0);
    add_reg(REG_GAIN_D, 12'hFFF);
    add_reg(REG_WINDUP, 12'd180);
    add_reg(REG_SETTLE, 12'd0);
    add_checked(9'd180, 1'b1, 8'sd100, 1'b1, 8'd180, 1'b0);
    add_checked(9'd0, 1'b0, -8'sd100, 1'b1, 8'd0, 1'b1);
    // all gains off: no drive at all, quarter turn the other way is left
    add_reg(REG_GAIN_P, 12'd0);
    add_reg(REG_GAIN_D, 12'd0);
    add_checked(9'd90, 1'b0, 8'sd0, 1'b0, 8'd90, 1'b0);
    // byte registers keep only their low bits
    add_reg(REG_WINDUP, 12'hFFF);
    add_reg(REG_SETTLE, 12'hFFF);
    add_checked(9'd200, 1'b0, 8'sd0, 1'b1, 8'd160, 1'b1);
    add_step(9'd45, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.is_reg) begin
        wait_idle();
        write_reg(row.idx, row.val);
      end else begin
        push_heading(row.heading, row.start_req, row.typed, row.want);
      end
    end

    // mixed phases: random settings, headings mostly near the target
    for (int p = 0; p < MIX_PHASES; p++) begin
      wait_idle();
      smooth = (p == 2);
      write_reg(REG_TARGET, ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                                         : 12'($urandom_range(0, 359)));
      write_reg(REG_GAIN_P, pick_gain());
      write_reg(REG_GAIN_I, pick_gain());
      write_reg(REG_GAIN_D, pick_gain());
      write_reg(REG_WINDUP, pick_band());
      write_reg(REG_SETTLE, pick_band());
      for (int n = 0; n < MIX_WORDS; n++) begin
        // long output stall while words keep coming, fills the queue
        if (p == 1 && n == 5) hold_off_pending = 1'b1;
        // sender waits for the block to empty mid-phase
        if (p == 3 && n == 15) wait_idle();
        case ($urandom_range(0, 9))
          7, 8: hd = int'($urandom_range(0, 359));
          9: hd = int'($urandom_range(0, 511));
          default: begin
            tgt  = int'(steer_cfg.target_heading) % 360;
            span = int'(steer_cfg.windup_band) + 2;
            if (span > 180) span = 180;
            hd = tgt + int'($urandom_range(0, 2 * span)) - span;
            hd = ((hd % 360) + 360) % 360;
          end
        endcase
        push_heading(9'(hd), ($urandom_range(0, 24) == 0), 1'b0, '0);
      end
    end

    // soak: large errors never clear the sum, so it must stick at its top
    wait_idle();
    smooth = 1'b0;
    write_reg(REG_TARGET, 12'd0);
    write_reg(REG_GAIN_P, 12'd0);
    write_reg(REG_GAIN_I, 12'd1);
    write_reg(REG_GAIN_D, 12'd0);
    write_reg(REG_WINDUP, 12'd180);
    write_reg(REG_SETTLE, 12'd0);
    push_heading(9'd180, 1'b1, 1'b0, '0);
    for (int n = 0; n < SOAK_WORDS; n++)
      push_heading(9'($urandom_range(176, 184)), 1'b0, 1'b0, '0);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_words == 0 && pending_drive.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // output side: random stalls, a long hold-off on request, smooth stretches
  initial begin : drain_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        stall_left       = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && !smooth && out_ready) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : word_check
    drive_word_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = drive_word_t'(out_data[17:0]);
      if (pending_drive.size() == 0) begin
        if (bad_words < MAX_REPORTS) $display("result word %h with nothing expected", out_data);
        bad_words++;
      end else begin
        want = pending_drive.pop_front();
        if (got.drive !== want.drive || got.turn_right !== want.turn_right ||
            got.err !== want.err || got.settled !== want.settled) begin
          if (bad_words < MAX_REPORTS)
            $display("mismatch: drive %0d/%0d right %b/%b err %0d/%0d settled %b/%b (exp/got)",
                     want.drive, got.drive, want.turn_right, got.turn_right,
                     want.err, got.err, want.settled, got.settled);
          bad_words++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hdl/hptc_pkg.sv
hdl/hptc_front.sv
hdl/hptc_queue.sv
hdl/hptc_back.sv
hdl/heading_pid_turn_controller.sv
bench/heading_pid_turn_controller_test.sv
